FILE: hdl/s2c_pkg.sv
// Shared types, widths and constants for the spherical to Cartesian unit.
// Holds the CORDIC arctangent table and the per-stage beat structure.
// No dependencies.
package s2c_pkg;

   localparam int ANG_W       = 17;
   localparam int AZ_W        = 16;
   localparam int INC_W       = 15;
   localparam int XY_W        = 32;
   localparam int Z_W         = 32;
   localparam int Q15_W       = 16;
   localparam int ANGLE_SHIFT = 15;
   localparam int TABLE_LEN   = 24;
   localparam int IDX_W       = 5;

   localparam logic signed [ANG_W-1:0] DEG90  = 17'sd11520;
   localparam logic signed [ANG_W-1:0] DEG180 = 17'sd23040;
   localparam logic signed [ANG_W-1:0] DEG360 = 17'sd46080;

   localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sd652032874;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   neg_cos;
   } lane_type;

   typedef struct packed {
      logic     valid;
      lane_type inc;
      lane_type az;
   } stage_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = 32'sd188743680;
         5'd1:    v = 32'sd111421900;
         5'd2:    v = 32'sd58872272;
         5'd3:    v = 32'sd29884485;
         5'd4:    v = 32'sd15000234;
         5'd5:    v = 32'sd7507429;
         5'd6:    v = 32'sd3754631;
         5'd7:    v = 32'sd1877430;
         5'd8:    v = 32'sd938729;
         5'd9:    v = 32'sd469366;
         5'd10:   v = 32'sd234683;
         5'd11:   v = 32'sd117342;
         5'd12:   v = 32'sd58671;
         5'd13:   v = 32'sd29335;
         5'd14:   v = 32'sd14668;
         5'd15:   v = 32'sd7334;
         5'd16:   v = 32'sd3667;
         5'd17:   v = 32'sd1833;
         5'd18:   v = 32'sd917;
         5'd19:   v = 32'sd458;
         5'd20:   v = 32'sd229;
         5'd21:   v = 32'sd115;
         5'd22:   v = 32'sd57;
         5'd23:   v = 32'sd29;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/s2c_fold.sv
// Input stage: wraps both angles into [-180, 180] degrees, folds them into
// [-90, 90] degrees and loads the first CORDIC beat. Depends on s2c_pkg.
module s2c_fold (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_in,
   input  logic signed [s2c_pkg::AZ_W-1:0]     azimuth_deg,
   input  logic        [s2c_pkg::INC_W-1:0]    inclination_deg,
   output s2c_pkg::stage_type                  stage_out
);
   import s2c_pkg::*;

   stage_type stage_ff;
   stage_type stage_in;

   function automatic lane_type load_lane(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] w;
      logic signed [ANG_W-1:0] f;
      logic                    neg;
      logic signed [Z_W-1:0]   ze;
      lane_type                l;
      w = a;
      if (a > DEG180) begin
         w = a - DEG360;
      end else if (a < -DEG180) begin
         w = a + DEG360;
      end
      f   = w;
      neg = 1'b0;
      if (w > DEG90) begin
         f   = DEG180 - w;
         neg = 1'b1;
      end else if (w < -DEG90) begin
         f   = -DEG180 - w;
         neg = 1'b1;
      end
      ze        = Z_W'(f);
      l.x       = GAIN_Q30;
      l.y       = '0;
      l.z       = ze <<< ANGLE_SHIFT;
      l.neg_cos = neg;
      return l;
   endfunction

   always_comb begin
      stage_in.valid = valid_in;
      stage_in.az    = load_lane(ANG_W'(azimuth_deg));
      stage_in.inc   = load_lane(signed'({2'b00, inclination_deg}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.az  <= stage_in.az;
      stage_ff.inc <= stage_in.inc;
   end

   assign stage_out = stage_ff;

endmodule

FILE: hdl/s2c_cell.sv
// One CORDIC rotation cell: a single micro-rotation of both angle lanes,
// registered and handed to the next cell. Depends on s2c_pkg.
module s2c_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  s2c_pkg::stage_type   stage_in,
   output s2c_pkg::stage_type   stage_out
);
   import s2c_pkg::*;

   localparam logic [IDX_W-1:0] IDX = IDX_W'(STAGE);

   stage_type stage_ff;
   stage_type stage_nx_in;

   function automatic lane_type rotate(input lane_type l);
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  zs;
      logic signed [Z_W-1:0]  at;
      lane_type               r;
      xs = l.x;
      ys = l.y;
      zs = l.z;
      dx = ys >>> STAGE;
      dy = xs >>> STAGE;
      at = atan_entry(IDX);
      r.neg_cos = l.neg_cos;
      if (!zs[Z_W-1]) begin
         r.x = xs - dx;
         r.y = ys + dy;
         r.z = zs - at;
      end else begin
         r.x = xs + dx;
         r.y = ys - dy;
         r.z = zs + at;
      end
      return r;
   endfunction

   always_comb begin
      stage_nx_in.valid = stage_in.valid;
      stage_nx_in.inc   = rotate(stage_in.inc);
      stage_nx_in.az    = rotate(stage_in.az);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_nx_in.valid;
      end
      stage_ff.inc <= stage_nx_in.inc;
      stage_ff.az  <= stage_nx_in.az;
   end

   assign stage_out = stage_ff;

endmodule

FILE: hdl/s2c_finish.sv
// Output stages: round and saturate sine and cosine to Q1.15, then form
// x and y as products with the flat radius. Depends on s2c_pkg.
module s2c_finish (
   input  logic                                clock,
   input  logic                                reset,
   input  s2c_pkg::stage_type                  stage_in,
   output logic                                rsp_valid,
   output logic signed [s2c_pkg::Q15_W-1:0]    rsp_x_out,
   output logic signed [s2c_pkg::Q15_W-1:0]    rsp_y_out,
   output logic signed [s2c_pkg::Q15_W-1:0]    rsp_z_out
);
   import s2c_pkg::*;

   localparam int EXT_W = XY_W + 1;
   localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(16384);

   logic                    trig_valid_ff;
   logic signed [Q15_W-1:0] sin_inc_ff;
   logic signed [Q15_W-1:0] cos_inc_ff;
   logic signed [Q15_W-1:0] sin_az_ff;
   logic signed [Q15_W-1:0] cos_az_ff;
   logic signed [Q15_W-1:0] sin_inc_in;
   logic signed [Q15_W-1:0] cos_inc_in;
   logic signed [Q15_W-1:0] sin_az_in;
   logic signed [Q15_W-1:0] cos_az_in;

   logic                    out_valid_ff;
   logic signed [Q15_W-1:0] x_ff;
   logic signed [Q15_W-1:0] y_ff;
   logic signed [Q15_W-1:0] z_ff;
   logic signed [Q15_W-1:0] x_in;
   logic signed [Q15_W-1:0] y_in;

   function automatic logic signed [Q15_W-1:0] round_sat(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] r;
      logic signed [Q15_W-1:0] o;
      r = (v + HALF_LSB) >>> 15;
      if (r > EXT_W'(32767)) begin
         o = 16'sh7fff;
      end else if (r < -EXT_W'(32768)) begin
         o = 16'sh8000;
      end else begin
         o = Q15_W'(r);
      end
      return o;
   endfunction

   function automatic logic signed [Q15_W-1:0] cos_of(input lane_type l);
      logic signed [EXT_W-1:0] xe;
      xe = EXT_W'(l.x);
      if (l.neg_cos) begin
         xe = -xe;
      end
      return round_sat(xe);
   endfunction

   function automatic logic signed [Q15_W-1:0] mul_q15(input logic signed [Q15_W-1:0] a,
                                                       input logic signed [Q15_W-1:0] b);
      logic signed [2*Q15_W-1:0] p;
      p = (2*Q15_W)'(a) * (2*Q15_W)'(b);
      return round_sat(EXT_W'(p));
   endfunction

   always_comb begin
      sin_inc_in = round_sat(EXT_W'(stage_in.inc.y));
      cos_inc_in = cos_of(stage_in.inc);
      sin_az_in  = round_sat(EXT_W'(stage_in.az.y));
      cos_az_in  = cos_of(stage_in.az);
      x_in       = mul_q15(sin_inc_ff, cos_az_ff);
      y_in       = mul_q15(sin_inc_ff, sin_az_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         trig_valid_ff <= stage_in.valid;
         out_valid_ff  <= trig_valid_ff;
      end
      sin_inc_ff <= sin_inc_in;
      cos_inc_ff <= cos_inc_in;
      sin_az_ff  <= sin_az_in;
      cos_az_ff  <= cos_az_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= cos_inc_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_x_out = x_ff;
   assign rsp_y_out = y_ff;
   assign rsp_z_out = z_ff;

endmodule

FILE: hdl/spherical_to_cartesian_unit.sv
// Spherical to Cartesian unit vector converter, top level.
// Depends on s2c_pkg, s2c_fold, s2c_cell and s2c_finish.
//
// Usage:
//   Drive req_azimuth_deg and req_inclination_deg (1/128 degree) and raise
//   start for one cycle per direction; a beat is taken on every edge where
//   start is high and busy is low. busy stays low: the datapath is a fully
//   pipelined row of CORDIC cells, so a new beat can enter every cycle.
//   The result (x, y, z in Q1.15) appears on rsp_x_out, rsp_y_out and
//   rsp_z_out for exactly one cycle with rsp_valid high.
//   Each beat passes through the angle wrap and fold register, a register
//   in every CORDIC cell, the rounding to Q1.15 register and the radius
//   multiplication register. Throughput is one beat per cycle.
//   Results come out in input order. The receiver cannot stall the unit:
//   each result must be captured in the cycle its strobe is high.
//   A synchronous reset drops every beat in flight; no result follows for
//   beats taken before reset.
module spherical_to_cartesian_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [s2c_pkg::AZ_W-1:0]     req_azimuth_deg,
   input  logic        [s2c_pkg::INC_W-1:0]    req_inclination_deg,
   output logic                                rsp_valid,
   output logic signed [s2c_pkg::Q15_W-1:0]    rsp_x_out,
   output logic signed [s2c_pkg::Q15_W-1:0]    rsp_y_out,
   output logic signed [s2c_pkg::Q15_W-1:0]    rsp_z_out
);
   import s2c_pkg::*;

   stage_type chain [CORDIC_STAGES+1];
   logic      accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   s2c_fold u_fold (
      .clock           (clock),
      .reset           (reset),
      .valid_in        (accept),
      .azimuth_deg     (req_azimuth_deg),
      .inclination_deg (req_inclination_deg),
      .stage_out       (chain[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      s2c_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   s2c_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (chain[CORDIC_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_x_out (rsp_x_out),
      .rsp_y_out (rsp_y_out),
      .rsp_z_out (rsp_z_out)
   );

endmodule
